@@ hw/rtl/bvrs_pkg.sv @@
`default_nettype none
package bvrs_pkg;

	localparam int MAX_BYTES_DEF       = 4096;
	localparam int SAMPLE_INTERVAL_DEF = 8;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_APPEND  = 2'd0,
		OP_RANK    = 2'd1,
		OP_SELECT  = 2'd2,
		OP_RESTART = 2'd3
	} opcode_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_ACCEPT,
		DP_ERR,
		DP_DIV_INIT,
		DP_DIV_STEP,
		DP_RANK_DIR,
		DP_TOTAL_LOAD,
		DP_STORE_RD,
		DP_RANK_ACC,
		DP_PART_RD,
		DP_RANK_FIN,
		DP_SRCH_INIT,
		DP_PROBE_RD,
		DP_PROBE_CMP,
		DP_LO_RD,
		DP_SEL_ACC,
		DP_EMIT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RANK_CHK,
		S_DIV,
		S_RANK_DIR,
		S_RANK_INIT,
		S_RANK_RD,
		S_RANK_ACC,
		S_PART_RD,
		S_PART,
		S_SEL_CHK,
		S_SRCH,
		S_PROBE,
		S_SEL_INIT,
		S_SEL_RD,
		S_SEL_ACC,
		S_DONE
	} ctl_state_t;

	typedef struct packed {
		opcode_t in_op;
		logic    rank_oob;
		logic    sel_bad;
		logic    scan_more;
		logic    search_more;
		logic    scan_end;
		logic    sel_hit;
	} dp_status_t;

	function automatic logic [3:0] pop8(input logic [7:0] v);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 8; i++) begin
			c = c + {3'd0, v[i]};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bvrs_if.sv @@
`default_nettype none
interface bvrs_in_if;
	logic              valid;
	logic              ready;
	bvrs_pkg::opcode_t opcode;
	logic [7:0]        data_byte;
	logic [15:0]       query;

	modport source (output valid, output opcode, output data_byte, output query, input ready);
	modport sink (input valid, input opcode, input data_byte, input query, output ready);
endinterface

interface bvrs_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] answer;
	logic        error;

	modport source (output valid, output answer, output error, input ready);
	modport sink (input valid, input answer, input error, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/bvrs_ctl.sv @@
`default_nettype none
module bvrs_ctl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire bvrs_pkg::dp_status_t status,
	output bvrs_pkg::dp_op_t          op
);

	bvrs_pkg::ctl_state_t state_q, state_d;
	logic                 out_valid_q;
	logic                 out_free;

	assign in_ready  = (state_q == bvrs_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bvrs_pkg::S_IDLE: begin
				if (in_valid) begin
					case (status.in_op)
						bvrs_pkg::OP_RANK:   state_d = bvrs_pkg::S_RANK_CHK;
						bvrs_pkg::OP_SELECT: state_d = bvrs_pkg::S_SEL_CHK;
						default:             state_d = bvrs_pkg::S_IDLE;
					endcase
				end
			end
			bvrs_pkg::S_RANK_CHK: state_d = status.rank_oob ? bvrs_pkg::S_DONE : bvrs_pkg::S_DIV;
			bvrs_pkg::S_DIV:      state_d = bvrs_pkg::S_RANK_DIR;
			bvrs_pkg::S_RANK_DIR: state_d = bvrs_pkg::S_RANK_INIT;
			bvrs_pkg::S_RANK_INIT,
			bvrs_pkg::S_RANK_ACC: begin
				state_d = status.scan_more ? bvrs_pkg::S_RANK_RD : bvrs_pkg::S_PART_RD;
			end
			bvrs_pkg::S_RANK_RD: state_d = bvrs_pkg::S_RANK_ACC;
			bvrs_pkg::S_PART_RD: state_d = bvrs_pkg::S_PART;
			bvrs_pkg::S_PART:    state_d = bvrs_pkg::S_DONE;
			bvrs_pkg::S_SEL_CHK: state_d = status.sel_bad ? bvrs_pkg::S_DONE : bvrs_pkg::S_SRCH;
			bvrs_pkg::S_SRCH: begin
				state_d = status.search_more ? bvrs_pkg::S_PROBE : bvrs_pkg::S_SEL_INIT;
			end
			bvrs_pkg::S_PROBE:    state_d = bvrs_pkg::S_SRCH;
			bvrs_pkg::S_SEL_INIT: state_d = bvrs_pkg::S_SEL_RD;
			bvrs_pkg::S_SEL_RD: begin
				state_d = status.scan_end ? bvrs_pkg::S_DONE : bvrs_pkg::S_SEL_ACC;
			end
			bvrs_pkg::S_SEL_ACC: state_d = status.sel_hit ? bvrs_pkg::S_DONE : bvrs_pkg::S_SEL_RD;
			bvrs_pkg::S_DONE: begin
				if (out_free) begin
					state_d = bvrs_pkg::S_IDLE;
				end
			end
			default: state_d = bvrs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		op = bvrs_pkg::DP_NOP;
		case (state_q)
			bvrs_pkg::S_IDLE:      op = in_valid ? bvrs_pkg::DP_ACCEPT : bvrs_pkg::DP_NOP;
			bvrs_pkg::S_RANK_CHK:  op = status.rank_oob ? bvrs_pkg::DP_ERR : bvrs_pkg::DP_DIV_INIT;
			bvrs_pkg::S_DIV:       op = bvrs_pkg::DP_DIV_STEP;
			bvrs_pkg::S_RANK_DIR:  op = bvrs_pkg::DP_RANK_DIR;
			bvrs_pkg::S_RANK_INIT: op = bvrs_pkg::DP_TOTAL_LOAD;
			bvrs_pkg::S_RANK_RD:   op = bvrs_pkg::DP_STORE_RD;
			bvrs_pkg::S_RANK_ACC:  op = bvrs_pkg::DP_RANK_ACC;
			bvrs_pkg::S_PART_RD:   op = bvrs_pkg::DP_PART_RD;
			bvrs_pkg::S_PART:      op = bvrs_pkg::DP_RANK_FIN;
			bvrs_pkg::S_SEL_CHK:   op = status.sel_bad ? bvrs_pkg::DP_ERR : bvrs_pkg::DP_SRCH_INIT;
			bvrs_pkg::S_SRCH: begin
				op = status.search_more ? bvrs_pkg::DP_PROBE_RD : bvrs_pkg::DP_LO_RD;
			end
			bvrs_pkg::S_PROBE:     op = bvrs_pkg::DP_PROBE_CMP;
			bvrs_pkg::S_SEL_INIT:  op = bvrs_pkg::DP_TOTAL_LOAD;
			bvrs_pkg::S_SEL_RD:    op = status.scan_end ? bvrs_pkg::DP_ERR : bvrs_pkg::DP_STORE_RD;
			bvrs_pkg::S_SEL_ACC:   op = bvrs_pkg::DP_SEL_ACC;
			bvrs_pkg::S_DONE:      op = out_free ? bvrs_pkg::DP_EMIT : bvrs_pkg::DP_NOP;
			default:               op = bvrs_pkg::DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bvrs_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (op == bvrs_pkg::DP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/bvrs_dp.sv @@
`default_nettype none
module bvrs_dp #(
	parameter int MAX_BYTES       = bvrs_pkg::MAX_BYTES_DEF,
	parameter int SAMPLE_INTERVAL = bvrs_pkg::SAMPLE_INTERVAL_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bvrs_pkg::dp_op_t  op,
	input  wire bvrs_pkg::opcode_t in_opcode,
	input  wire logic [7:0]        in_data_byte,
	input  wire logic [15:0]       in_query,
	output bvrs_pkg::dp_status_t   status,
	output logic [15:0]            answer,
	output logic                   error
);

	localparam int DIR_DEPTH = (MAX_BYTES + SAMPLE_INTERVAL - 1) / SAMPLE_INTERVAL;
	localparam int ADDR_W    = $clog2(MAX_BYTES);
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);
	localparam int DIR_AW    = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
	localparam int ENT_W     = $clog2(DIR_DEPTH + 1);
	localparam int PH_W      = (SAMPLE_INTERVAL > 1) ? $clog2(SAMPLE_INTERVAL) : 1;
	localparam int REM_W     = $clog2(SAMPLE_INTERVAL) + 2;
	localparam int MUL_W     = ENT_W + 7;
	localparam int POS_W     = CNT_W + 3;
	localparam int DIV_SH    = 20;
	localparam int DIV_M     = (2**DIV_SH + SAMPLE_INTERVAL - 1) / SAMPLE_INTERVAL;
	localparam int DIVP_W    = ADDR_W + DIV_SH + 1;
	localparam int BACK_W    = ADDR_W + 7;

	logic [7:0]  store_mem [MAX_BYTES];
	logic [15:0] dir_mem [DIR_DEPTH];

	logic [CNT_W-1:0]  bytes_q;
	logic [15:0]       run_q;
	logic [ENT_W-1:0]  entries_q;
	logic [PH_W-1:0]   phase_q;

	logic [15:0]       query_q;
	logic [7:0]        store_rd_q;
	logic [15:0]       dir_rd_q;
	logic [ADDR_W-1:0] div_num_q;
	logic [REM_W-1:0]  div_rem_q;
	logic [CNT_W-1:0]  b_q;
	logic [REM_W-1:0]  cnt_q;
	logic [16:0]       tot_q;
	logic [ENT_W-1:0]  lo_q;
	logic [ENT_W-1:0]  hi_q;
	logic [15:0]       res_ans_q;
	logic              res_err_q;
	logic [15:0]       answer_q;
	logic              error_q;

	logic              do_append;
	logic [16:0]       run_sum;
	logic [ADDR_W-1:0] pos_byte;
	logic [DIVP_W-1:0] div_prod;
	logic [BACK_W-1:0] div_back;
	logic [ENT_W-1:0]  mid;
	logic [MUL_W-1:0]  sel_base;
	logic              store_re;
	logic [ADDR_W-1:0] store_ra;
	logic              dir_re;
	logic [DIR_AW-1:0] dir_ra;
	logic [3:0]        byte_pop;
	logic [16:0]       acc_sum;
	logic              sel_hit;
	logic [2:0]        hit_bit;
	logic [POS_W-1:0]  hit_pos;
	logic [16:0]       part_sum;

	assign do_append = (op == bvrs_pkg::DP_ACCEPT) && (in_opcode == bvrs_pkg::OP_APPEND)
		&& (bytes_q < CNT_W'(MAX_BYTES));
	assign run_sum   = {1'b0, run_q} + 17'(bvrs_pkg::pop8(in_data_byte));
	assign pos_byte  = ADDR_W'(query_q[15:3]);
	assign div_prod  = DIVP_W'(pos_byte) * DIVP_W'(DIV_M);
	assign div_back  = BACK_W'(pos_byte) - BACK_W'(div_num_q) * BACK_W'(SAMPLE_INTERVAL);
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign sel_base  = MUL_W'(lo_q) * MUL_W'(SAMPLE_INTERVAL);
	assign byte_pop  = bvrs_pkg::pop8(store_rd_q);
	assign acc_sum   = tot_q + 17'(byte_pop);
	assign sel_hit   = (acc_sum >= {1'b0, query_q});
	assign hit_pos   = {b_q, 3'b000} + POS_W'(hit_bit);
	assign part_sum  = tot_q + 17'(bvrs_pkg::pop8(store_rd_q & (8'hFF << (3'd7 - query_q[2:0]))));

	// locate the bit that brings the count up to the requested rank, MSB first
	always_comb begin
		logic [3:0] need;
		logic [3:0] acc;
		logic       found;
		need    = 4'(query_q - tot_q[15:0]);
		acc     = 4'd0;
		found   = 1'b0;
		hit_bit = 3'd0;
		for (int i = 0; i < 8; i++) begin
			acc = acc + {3'd0, store_rd_q[7-i]};
			if (!found && (acc >= need)) begin
				found   = 1'b1;
				hit_bit = 3'(i);
			end
		end
	end

	always_comb begin
		store_re = (op == bvrs_pkg::DP_STORE_RD) || (op == bvrs_pkg::DP_PART_RD);
		store_ra = (op == bvrs_pkg::DP_PART_RD) ? pos_byte : b_q[ADDR_W-1:0];
		dir_re   = 1'b1;
		dir_ra   = lo_q[DIR_AW-1:0];
		case (op)
			bvrs_pkg::DP_RANK_DIR: dir_ra = div_num_q[DIR_AW-1:0];
			bvrs_pkg::DP_PROBE_RD: dir_ra = mid[DIR_AW-1:0];
			bvrs_pkg::DP_LO_RD:    dir_ra = lo_q[DIR_AW-1:0];
			default:               dir_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_append) begin
			store_mem[bytes_q[ADDR_W-1:0]] <= in_data_byte;
			if (phase_q == '0) begin
				dir_mem[entries_q[DIR_AW-1:0]] <= run_q;
			end
		end
		if (store_re) begin
			store_rd_q <= store_mem[store_ra];
		end
		if (dir_re) begin
			dir_rd_q <= dir_mem[dir_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q   <= '0;
			run_q     <= '0;
			entries_q <= '0;
			phase_q   <= '0;
		end else if (op == bvrs_pkg::DP_ACCEPT) begin
			if (in_opcode == bvrs_pkg::OP_RESTART) begin
				bytes_q   <= '0;
				run_q     <= '0;
				entries_q <= '0;
				phase_q   <= '0;
			end else if (do_append) begin
				bytes_q <= bytes_q + CNT_W'(1);
				run_q   <= run_sum[16] ? bvrs_pkg::COUNT_MAX : run_sum[15:0];
				if (phase_q == '0) begin
					entries_q <= entries_q + ENT_W'(1);
				end
				phase_q <= (phase_q == PH_W'(SAMPLE_INTERVAL - 1)) ? '0 : phase_q + PH_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			bvrs_pkg::DP_ACCEPT: query_q <= in_query;
			bvrs_pkg::DP_ERR: begin
				res_ans_q <= '0;
				res_err_q <= 1'b1;
			end
			bvrs_pkg::DP_DIV_INIT: div_num_q <= ADDR_W'(div_prod >> DIV_SH);
			bvrs_pkg::DP_DIV_STEP: div_rem_q <= div_back[REM_W-1:0];
			bvrs_pkg::DP_RANK_DIR: begin
				b_q   <= CNT_W'(pos_byte) - CNT_W'(div_rem_q);
				cnt_q <= div_rem_q;
			end
			bvrs_pkg::DP_TOTAL_LOAD: tot_q <= {1'b0, dir_rd_q};
			bvrs_pkg::DP_STORE_RD:   cnt_q <= cnt_q - REM_W'(1);
			bvrs_pkg::DP_RANK_ACC: begin
				tot_q <= acc_sum;
				b_q   <= b_q + CNT_W'(1);
			end
			bvrs_pkg::DP_RANK_FIN: begin
				res_ans_q <= part_sum[16] ? bvrs_pkg::COUNT_MAX : part_sum[15:0];
				res_err_q <= 1'b0;
			end
			bvrs_pkg::DP_SRCH_INIT: begin
				lo_q <= '0;
				hi_q <= entries_q;
			end
			bvrs_pkg::DP_PROBE_RD: hi_q <= hi_q;
			bvrs_pkg::DP_PROBE_CMP: begin
				if (dir_rd_q < query_q) begin
					lo_q <= mid;
				end else begin
					hi_q <= mid;
				end
			end
			bvrs_pkg::DP_LO_RD: b_q <= CNT_W'(sel_base);
			bvrs_pkg::DP_SEL_ACC: begin
				if (sel_hit) begin
					res_ans_q <= (32'(hit_pos) > 32'(bvrs_pkg::COUNT_MAX)) ? bvrs_pkg::COUNT_MAX
						: 16'(hit_pos);
					res_err_q <= 1'b0;
				end else begin
					tot_q <= acc_sum;
					b_q   <= b_q + CNT_W'(1);
				end
			end
			bvrs_pkg::DP_EMIT: begin
				answer_q <= res_ans_q;
				error_q  <= res_err_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		status.in_op       = in_opcode;
		status.rank_oob    = (32'(query_q) >= (32'(bytes_q) << 3));
		status.sel_bad     = (query_q == '0) || (query_q > run_q);
		status.scan_more   = (cnt_q != '0);
		status.search_more = ((hi_q - lo_q) > ENT_W'(1));
		status.scan_end    = (b_q == bytes_q);
		status.sel_hit     = sel_hit;
	end

	assign answer = answer_q;
	assign error  = error_q;

endmodule
`default_nettype wire

@@ hw/rtl/bitvector_rank_select.sv @@
// Rank/select engine over a bit vector appended one byte per word (MSB of each byte is the
// lowest bit position), with a running-count directory sampled every SAMPLE_INTERVAL bytes,
// held with the bytes in on-chip memories; nothing needs clearing after reset. Append and
// restart words are absorbed in the idle state. For a rank, a reciprocal multiply yields the
// directory slot and a multiply-and-subtract the byte offset within it, then each byte of the
// scan costs one byte-memory read plus one accumulate. A select runs a binary search doing one
// directory read per probe, then a scan with one byte-memory read plus one accumulate per
// byte. Errors (position past the loaded bits, k of zero or past the set-bit total) are
// flagged by the check state and go straight to the result. Results sit in an output register,
// so the next word is taken while a result waits; a query that finishes before its
// predecessor is taken holds until it is.
`default_nettype none
module bitvector_rank_select #(
	parameter int MAX_BYTES       = bvrs_pkg::MAX_BYTES_DEF,
	parameter int SAMPLE_INTERVAL = bvrs_pkg::SAMPLE_INTERVAL_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bvrs_in_if.sink   request,
	bvrs_out_if.source response
);

	bvrs_pkg::dp_op_t     op;
	bvrs_pkg::dp_status_t status;

	bvrs_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (response.valid),
		.out_ready (response.ready),
		.status    (status),
		.op        (op)
	);

	bvrs_dp #(
		.MAX_BYTES       (MAX_BYTES),
		.SAMPLE_INTERVAL (SAMPLE_INTERVAL)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.in_opcode    (request.opcode),
		.in_data_byte (request.data_byte),
		.in_query     (request.query),
		.status       (status),
		.answer       (response.answer),
		.error        (response.error)
	);

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(request.valid && request.ready && (request.opcode == bvrs_pkg::OP_RANK
			|| request.opcode == bvrs_pkg::OP_SELECT)) |=> !request.ready)
		else $error("query accepted without entering its sequence");

	a_update_free: assert property (@(posedge clk) disable iff (!arst_n)
		(request.valid && request.ready && (request.opcode == bvrs_pkg::OP_APPEND
			|| request.opcode == bvrs_pkg::OP_RESTART)) |=> request.ready)
		else $error("append or restart did not finish in one cycle");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(op == bvrs_pkg::DP_EMIT) |=> response.valid)
		else $error("result loaded but not presented");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(op == bvrs_pkg::DP_EMIT) |-> (!response.valid || response.ready))
		else $error("result register overwritten while full");

endmodule
`default_nettype wire

@@ sim/tb_bitvector_rank_select.sv @@
`default_nettype none
module tb_bitvector_rank_select;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXB        = bvrs_pkg::MAX_BYTES_DEF;
	localparam int SI          = bvrs_pkg::SAMPLE_INTERVAL_DEF;
	localparam int DIRN        = (MAXB + SI - 1) / SI;
	localparam int SETTLE      = 80;
	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_WORDS = 800;
	localparam int LONG_HOLD   = 400;

	typedef struct packed {
		logic [15:0] answer;
		logic        error;
	} reply_t;

	logic clk;
	logic arst_n;

	bvrs_in_if  req_if ();
	bvrs_out_if rsp_if ();

	bitvector_rank_select #(
		.MAX_BYTES       (MAXB),
		.SAMPLE_INTERVAL (SI)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_if.sink),
		.response (rsp_if.source)
	);

	logic [7:0]  vec_bytes [MAXB];
	logic [15:0] dir_counts [DIRN];
	int unsigned vec_len;
	int unsigned set_total;
	reply_t      awaited_replies [$];

	int unsigned mismatches;
	int unsigned n_append;
	int unsigned n_rank;
	int unsigned n_select;
	int unsigned n_flagged;
	int unsigned longest_vec;
	int unsigned quiet_cycles = 0;
	int unsigned rx_hold;
	int          burst_left;
	bit          tx_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] clamp16(input int unsigned v);
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic void apply_word(input bvrs_pkg::opcode_t op, input logic [7:0] b,
					   input logic [15:0] q);
		int unsigned idx, d, t, lo, hi, mid, entries, keep, k;
		logic [15:0] ans;
		bit          err;
		bit          found;
		ans = '0;
		err = 1'b0;
		case (op)
		bvrs_pkg::OP_APPEND: begin
			if (vec_len < MAXB) begin
				if (vec_len % SI == 0)
					dir_counts[vec_len / SI] = set_total[15:0];
				vec_bytes[vec_len] = b;
				set_total = 32'(clamp16(set_total + $countones(b)));
				vec_len++;
				n_append++;
				if (vec_len > longest_vec)
					longest_vec = vec_len;
			end
			return;
		end
		bvrs_pkg::OP_RESTART: begin
			vec_len = 0;
			set_total = 0;
			return;
		end
		bvrs_pkg::OP_RANK: begin
			n_rank++;
			if (32'(q) >= vec_len * 8) begin
				err = 1'b1;
			end else begin
				idx = 32'(q) / 8;
				d = idx / SI;
				t = 32'(dir_counts[d]);
				for (int unsigned i = d * SI; i < idx; i++)
					t += $countones(vec_bytes[i]);
				keep = (32'(q) % 8) + 1;
				t += $countones(vec_bytes[idx] >> (8 - keep));
				ans = clamp16(t);
			end
		end
		default: begin
			n_select++;
			k = 32'(q);
			if (k == 0 || k > set_total) begin
				err = 1'b1;
			end else begin
				entries = (vec_len + SI - 1) / SI;
				lo = 0;
				hi = entries;
				while (hi - lo > 1) begin
					mid = lo + (hi - lo) / 2;
					if (32'(dir_counts[mid]) < k)
						lo = mid;
					else
						hi = mid;
				end
				t = 32'(dir_counts[lo]);
				found = 1'b0;
				for (int unsigned i = lo * SI; i < vec_len && !found; i++) begin
					for (int bit_i = 7; bit_i >= 0 && !found; bit_i--) begin
						t += 32'(vec_bytes[i][bit_i]);
						if (t >= k) begin
							found = 1'b1;
							ans = clamp16(i * 8 + 32'(7 - bit_i));
						end
					end
				end
				err = !found;
				if (err)
					ans = '0;
			end
		end
		endcase
		if (err)
			n_flagged++;
		awaited_replies.push_back('{answer: ans, error: err});
	endfunction

	task automatic send_word(input bvrs_pkg::opcode_t op, input logic [7:0] b,
				 input logic [15:0] q);
		req_if.valid     <= 1'b1;
		req_if.opcode    <= op;
		req_if.data_byte <= b;
		req_if.query     <= q;
		tx_on = 1'b1;
		do @(posedge clk); while (!req_if.ready);
		apply_word(op, b, q);
		burst_left = burst_left - 1;
		if (burst_left <= 0) begin
			req_if.valid <= 1'b0;
			tx_on = 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
								  : $urandom_range(1, 6);
		end
	endtask

	task automatic wait_drained();
		if (tx_on) begin
			req_if.valid <= 1'b0;
			tx_on = 1'b0;
		end
		do @(posedge clk); while (awaited_replies.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 5))
		0:       return 8'h00;
		1:       return 8'hFF;
		2:       return 8'h01 << $urandom_range(0, 7);
		default: return 8'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_position();
		int unsigned bits, r;
		bits = vec_len * 8;
		r = $urandom_range(0, 9);
		if (bits != 0 && r < 7)
			return 16'($urandom_range(0, bits - 1));
		if (bits != 0 && r == 7)
			return 16'(bits - 1);
		if (r == 8)
			return 16'(bits);
		return 16'($urandom());
	endfunction

	function automatic logic [15:0] pick_count();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (set_total != 0 && r < 7)
			return 16'($urandom_range(1, set_total));
		if (set_total != 0 && r == 7)
			return 16'(set_total);
		if (r == 8)
			return $urandom_range(0, 1) ? 16'd0 : 16'(set_total + 1);
		return 16'($urandom());
	endfunction

	task automatic send_query();
		if ($urandom_range(0, 1))
			send_word(bvrs_pkg::OP_RANK, 8'($urandom()), pick_position());
		else
			send_word(bvrs_pkg::OP_SELECT, 8'($urandom()), pick_count());
	endtask

	task automatic test_empty_vector();
		send_word(bvrs_pkg::OP_RANK, 8'h00, 16'd0);
		send_word(bvrs_pkg::OP_RANK, 8'hFF, 16'hFFFF);
		send_word(bvrs_pkg::OP_SELECT, 8'h00, 16'd0);
		send_word(bvrs_pkg::OP_SELECT, 8'hFF, 16'd1);
		send_word(bvrs_pkg::OP_SELECT, 8'h00, 16'hFFFF);
	endtask

	task automatic test_directed_patterns();
		logic [7:0]  pattern [9] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hA5,
					     8'h5A, 8'h00, 8'h10, 8'hC3};
		logic [15:0] positions [7] = '{16'd0, 16'd15, 16'd16, 16'd63, 16'd64,
					       16'd71, 16'd72};
		logic [15:0] counts [6] = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd23, 16'd24};
		send_word(bvrs_pkg::OP_RESTART, 8'h00, 16'd0);
		foreach (pattern[i])
			send_word(bvrs_pkg::OP_APPEND, pattern[i], 16'd0);
		foreach (positions[i])
			send_word(bvrs_pkg::OP_RANK, 8'h00, positions[i]);
		foreach (counts[i])
			send_word(bvrs_pkg::OP_SELECT, 8'h00, counts[i]);
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		send_word(bvrs_pkg::OP_RESTART, 8'h00, 16'd0);
		repeat (40)
			send_word(bvrs_pkg::OP_APPEND, rand_byte(), 16'd0);
		rx_hold = LONG_HOLD;
		repeat (16)
			send_query();
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int unsigned sent, run;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 19))
			0: begin
				send_word(bvrs_pkg::OP_RESTART, 8'($urandom()), 16'($urandom()));
				sent++;
			end
			1, 2, 3, 4, 5: begin
				run = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 200)
								   : $urandom_range(1, 16);
				repeat (run) begin
					if (vec_len >= 1500)
						send_word(bvrs_pkg::OP_RESTART, 8'($urandom()),
							  16'($urandom()));
					else
						send_word(bvrs_pkg::OP_APPEND, rand_byte(), 16'($urandom()));
					sent++;
				end
			end
			17, 18: begin
				send_word(bvrs_pkg::opcode_t'($urandom_range(0, 3)), 8'($urandom()),
					  16'($urandom()));
				sent++;
			end
			19: wait_drained();
			default: begin
				run = $urandom_range(1, 8);
				repeat (run) begin
					send_query();
					sent++;
				end
			end
			endcase
		end
		wait_drained();
	endtask

	initial begin
		int unsigned mode, mode_left, hold_left, tick;
		rsp_if.ready <= 1'b0;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (rx_hold != 0) begin
				hold_left = rx_hold;
				rx_hold = 0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 150);
			end
			mode_left--;
			if (!arst_n || hold_left != 0) begin
				if (hold_left != 0)
					hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				case (mode)
				0:       rsp_if.ready <= 1'b1;
				1:       rsp_if.ready <= ($urandom_range(0, 9) < 6);
				2:       rsp_if.ready <= (tick % 3 != 0);
				default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (awaited_replies.size() == 0) begin
				$display("%0t: unexpected word, expected none, got answer %0d error %0b",
					 $time, rsp_if.answer, rsp_if.error);
				mismatches++;
			end else begin
				want = awaited_replies.pop_front();
				if (rsp_if.answer !== want.answer) begin
					$display("%0t: answer mismatch, expected %0d, got %0d",
						 $time, want.answer, rsp_if.answer);
					mismatches++;
				end
				if (rsp_if.error !== want.error) begin
					$display("%0t: error flag mismatch, expected %0b, got %0b",
						 $time, want.error, rsp_if.error);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
			$display("tb_bitvector_rank_select failed");
			$finish;
		end
	end

	initial begin
		vec_len = 0;
		set_total = 0;
		mismatches = 0;
		n_append = 0;
		n_rank = 0;
		n_select = 0;
		n_flagged = 0;
		longest_vec = 0;
		rx_hold = 0;
		burst_left = 1;
		tx_on = 1'b0;
		arst_n           <= 1'b0;
		req_if.valid     <= 1'b0;
		req_if.opcode    <= bvrs_pkg::OP_APPEND;
		req_if.data_byte <= 8'h00;
		req_if.query     <= 16'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_vector();
		test_directed_patterns();
		test_output_backpressure();
		test_random_traffic();
		wait_drained();

		$display("Stored %0d bytes (longest vector %0d bytes), asked %0d rank and %0d select",
			 n_append, longest_vec, n_rank, n_select);
		$display("queries, %0d of them out of range; %0d mismatches", n_flagged, mismatches);
		if (mismatches == 0)
			$display("tb_bitvector_rank_select passed");
		else
			$display("tb_bitvector_rank_select failed");
		$finish;
	end

endmodule
`default_nettype wire
